// ===== hdl/tst_pkg.sv =====
// Shared types, token codes and character classification for the token scanner.
`default_nettype none

package tst_pkg;

  localparam int unsigned KwChars   = 8;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned ValW      = ValueBits - 1;
  localparam int unsigned WinW      = 8 * KwChars;
  localparam int unsigned LenW      = $clog2(KwChars + 2);

  localparam logic [ValW-1:0] ValueMax = '1;

  localparam logic [5:0] KIND_AND_AND = 6'd22;
  localparam logic [5:0] KIND_OR_OR   = 6'd23;
  localparam logic [5:0] KIND_NUMBER  = 6'd33;
  localparam logic [5:0] KIND_IDENT   = 6'd34;
  localparam logic [5:0] KIND_EOF     = 6'd53;
  localparam logic [5:0] KIND_NONE    = 6'd63;

  localparam logic [4:0] DIGIT_NONE = 5'h1f;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_OP, MODE_LCOM, MODE_BCOM, MODE_BSTAR, MODE_ZERO,
    MODE_DEC, MODE_SEP, MODE_PFX, MODE_PDIG, MODE_IDENT
  } mode_e;

  typedef struct packed {
    logic [5:0]      kind;
    logic [ValW-1:0] value;
    logic [15:0]     line;
    logic [15:0]     scol;
    logic [15:0]     ecol;
    logic            bad;
    logic            last;
  } tok_t;

  function automatic logic [5:0] punct_kind(logic [7:0] c);
    case (c)
      "(": return 6'd0;
      ")": return 6'd1;
      "[": return 6'd2;
      "]": return 6'd3;
      "{": return 6'd4;
      "}": return 6'd5;
      ":": return 6'd6;
      ";": return 6'd7;
      ".": return 6'd8;
      ",": return 6'd9;
      "^": return 6'd10;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c inside {"+", "-", "*", "/", "%", "!", ">", "<", "=", "&", "|"};
  endfunction

  function automatic logic [5:0] op_kind(logic [7:0] p);
    case (p)
      "+": return 6'd11;
      "-": return 6'd12;
      "*": return 6'd13;
      "/": return 6'd14;
      "%": return 6'd15;
      "!": return 6'd16;
      ">": return 6'd17;
      "<": return 6'd18;
      "=": return 6'd19;
      "&": return 6'd20;
      default: return 6'd21;
    endcase
  endfunction

  function automatic logic [5:0] assign_kind(logic [7:0] p);
    case (p)
      "+": return 6'd24;
      "-": return 6'd25;
      "*": return 6'd26;
      "/": return 6'd27;
      "%": return 6'd28;
      "!": return 6'd29;
      ">": return 6'd30;
      "<": return 6'd31;
      "=": return 6'd32;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic logic [4:0] radix_base(logic [1:0] r);
    case (r)
      2'd1: return 5'd2;
      2'd2: return 5'd8;
      2'd3: return 5'd16;
      default: return 5'd10;
    endcase
  endfunction

  function automatic logic [4:0] digit_of(logic [7:0] c, logic [4:0] base);
    logic [4:0] v;
    v = DIGIT_NONE;
    if (c inside {["0":"9"]}) v = 5'(c - 8'h30);
    else if (c inside {["a":"f"]}) v = 5'(c - 8'h57);
    return (v < base) ? v : DIGIT_NONE;
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"};
  endfunction

  // First character into the lowest byte, zero padded.
  function automatic logic [WinW-1:0] kw_pack(logic [WinW-1:0] s, int n);
    logic [WinW-1:0] w;
    w = '0;
    for (int i = 0; i < KwChars; i++) begin
      if (i < n) w[8*i +: 8] = s[8*(n-1-i) +: 8];
    end
    return w;
  endfunction

  function automatic logic [5:0] kw_kind(logic [WinW-1:0] w, logic [LenW-1:0] n);
    logic [5:0] k;
    k = KIND_IDENT;
    if (n == LenW'(3) && w == kw_pack("let", 3)) k = 6'd35;
    if (n == LenW'(4) && w == kw_pack("func", 4)) k = 6'd36;
    if (n == LenW'(6) && w == kw_pack("return", 6)) k = 6'd37;
    if (n == LenW'(7) && w == kw_pack("package", 7)) k = 6'd38;
    if (n == LenW'(6) && w == kw_pack("static", 6)) k = 6'd39;
    if (n == LenW'(2) && w == kw_pack("if", 2)) k = 6'd40;
    if (n == LenW'(4) && w == kw_pack("else", 4)) k = 6'd41;
    if (n == LenW'(5) && w == kw_pack("while", 5)) k = 6'd42;
    if (n == LenW'(2) && w == kw_pack("do", 2)) k = 6'd43;
    if (n == LenW'(6) && w == kw_pack("switch", 6)) k = 6'd44;
    if (n == LenW'(3) && w == kw_pack("for", 3)) k = 6'd45;
    if (n == LenW'(7) && w == kw_pack("foreach", 7)) k = 6'd46;
    if (n == LenW'(5) && w == kw_pack("break", 5)) k = 6'd47;
    if (n == LenW'(8) && w == kw_pack("breakall", 8)) k = 6'd48;
    if (n == LenW'(8) && w == kw_pack("continue", 8)) k = 6'd49;
    if (n == LenW'(4) && w == kw_pack("loop", 4)) k = 6'd50;
    if (n == LenW'(2) && w == kw_pack("in", 2)) k = 6'd51;
    if (n == LenW'(4) && w == kw_pack("true", 4)) k = 6'd52;
    if (n == LenW'(5) && w == kw_pack("false", 5)) k = 6'd52;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tst_core.sv =====
// Scanner state registers and the single-pass next-state and token logic.
`default_nettype none

module tst_core import tst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  char_i,
  input  wire logic        eoi_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output tok_t             tok0_o,
  output tok_t             tok1_o,
  output logic [1:0]       tok_cnt_o
);

  mode_e           mode_q, mode_d;
  logic [7:0]      pend_q, pend_d;
  logic [ValW-1:0] acc_q, acc_d;
  logic [1:0]      radix_q, radix_d;
  logic [WinW-1:0] win_q, win_d;
  logic [LenW-1:0] wlen_q, wlen_d;
  logic [15:0]     line_q, line_d;
  logic [15:0]     col_q, col_d;
  logic [15:0]     tstart_q, tstart_d;
  logic            err_q, err_d;

  logic            fin_vld;
  tok_t            fin_tok;
  logic            a_vld, b_vld;
  tok_t            a_tok, b_tok;
  logic [15:0]     col_inc, line_inc;
  logic [4:0]      base, dig;
  logic [ValW+4:0] acc_sum;
  logic [ValW-1:0] acc_nxt;
  logic            acc_ovf;
  logic [5:0]      pk;

  assign col_inc  = (col_q == 16'hffff) ? col_q : col_q + 16'd1;
  assign line_inc = (line_q == 16'hffff) ? line_q : line_q + 16'd1;

  // Token left open by the current state, flushed when the byte cannot extend it or at end of input.
  always_comb begin
    fin_vld = 1'b1;
    fin_tok = '0;
    fin_tok.line = line_q;
    fin_tok.scol = tstart_q;
    fin_tok.ecol = col_q;
    case (mode_q)
      MODE_OP: begin
        fin_tok.kind = op_kind(pend_q);
        fin_tok.ecol = tstart_q;
      end
      MODE_SEP, MODE_PFX: begin
        fin_tok.kind  = KIND_NUMBER;
        fin_tok.value = acc_q;
        fin_tok.bad   = 1'b1;
      end
      MODE_ZERO, MODE_DEC, MODE_PDIG: begin
        fin_tok.kind  = KIND_NUMBER;
        fin_tok.value = acc_q;
        fin_tok.bad   = err_q;
      end
      MODE_IDENT: fin_tok.kind = kw_kind(win_q, wlen_q);
      default:    fin_vld = 1'b0;
    endcase
  end

  // Saturating multiply-add by a base of 2, 8, 10 or 16.
  always_comb begin
    base = (mode_q == MODE_PFX || mode_q == MODE_PDIG) ? radix_base(radix_q) : 5'd10;
    dig  = digit_of(char_i, base);
    case (base)
      5'd2:    acc_sum = {4'd0, acc_q, 1'b0};
      5'd8:    acc_sum = {2'd0, acc_q, 3'd0};
      5'd16:   acc_sum = {1'd0, acc_q, 4'd0};
      default: acc_sum = {2'd0, acc_q, 3'd0} + {4'd0, acc_q, 1'b0};
    endcase
    acc_sum = acc_sum + {(ValW+1)'(0), dig[3:0]};
    acc_ovf = acc_sum > {5'd0, ValueMax};
    acc_nxt = acc_ovf ? ValueMax : acc_sum[ValW-1:0];
  end

  always_comb begin
    logic rescan;
    rescan   = 1'b0;
    mode_d   = mode_q;
    pend_d   = pend_q;
    acc_d    = acc_q;
    radix_d  = radix_q;
    win_d    = win_q;
    wlen_d   = wlen_q;
    line_d   = line_q;
    col_d    = col_q;
    tstart_d = tstart_q;
    err_d    = err_q;
    a_vld    = 1'b0;
    a_tok    = '0;
    b_vld    = 1'b0;
    b_tok    = '0;
    pk       = punct_kind(char_i);
    if (step_i) begin
      if (eoi_i) begin
        a_vld      = fin_vld;
        a_tok      = fin_tok;
        mode_d     = MODE_IDLE;
        line_d     = line_inc;
        b_vld      = 1'b1;
        b_tok.kind = KIND_EOF;
        b_tok.line = line_inc;
      end else begin
        col_d = col_inc;
        case (mode_q)
          MODE_OP: begin
            if (pend_q == "/" && char_i == "/") begin
              mode_d = MODE_LCOM;
            end else if (pend_q == "/" && char_i == "*") begin
              mode_d = MODE_BCOM;
            end else if (char_i == "=" && assign_kind(pend_q) != KIND_NONE) begin
              a_vld      = 1'b1;
              a_tok.kind = assign_kind(pend_q);
              mode_d     = MODE_IDLE;
            end else if (char_i == pend_q && (char_i == "&" || char_i == "|")) begin
              a_vld      = 1'b1;
              a_tok.kind = (char_i == "&") ? KIND_AND_AND : KIND_OR_OR;
              mode_d     = MODE_IDLE;
            end else begin
              rescan = 1'b1;
            end
            a_tok.line = line_q;
            a_tok.scol = tstart_q;
            a_tok.ecol = col_inc;
          end
          MODE_LCOM: begin
            if (char_i == 8'h0a) begin
              line_d = line_inc;
              col_d  = '0;
              mode_d = MODE_IDLE;
            end
          end
          MODE_BCOM, MODE_BSTAR: begin
            if (mode_q == MODE_BSTAR && char_i == "/") begin
              mode_d = MODE_IDLE;
            end else if (char_i == "*") begin
              mode_d = MODE_BSTAR;
            end else begin
              mode_d = MODE_BCOM;
              if (char_i == 8'h0a) begin
                line_d = line_inc;
                col_d  = '0;
              end
            end
          end
          MODE_ZERO, MODE_DEC, MODE_SEP: begin
            if (mode_q == MODE_ZERO && char_i inside {"b", "o", "d", "x"}) begin
              case (char_i)
                "b":     radix_d = 2'd1;
                "o":     radix_d = 2'd2;
                "x":     radix_d = 2'd3;
                default: radix_d = 2'd0;
              endcase
              mode_d = MODE_PFX;
            end else if (dig != DIGIT_NONE) begin
              acc_d  = acc_nxt;
              err_d  = err_q | acc_ovf;
              mode_d = MODE_DEC;
            end else if (char_i == "_" && mode_q != MODE_SEP) begin
              mode_d = MODE_SEP;
            end else begin
              rescan = 1'b1;
            end
          end
          MODE_PFX, MODE_PDIG: begin
            if (dig != DIGIT_NONE) begin
              acc_d  = acc_nxt;
              err_d  = err_q | acc_ovf;
              mode_d = MODE_PDIG;
            end else begin
              rescan = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_word(char_i)) begin
              if (wlen_q < LenW'(KwChars)) win_d[8*wlen_q[$clog2(KwChars)-1:0] +: 8] = char_i;
              if (wlen_q <= LenW'(KwChars)) wlen_d = wlen_q + LenW'(1);
            end else begin
              rescan = 1'b1;
            end
          end
          default: rescan = 1'b1;
        endcase
        if (rescan) begin
          a_vld  = fin_vld;
          a_tok  = fin_tok;
          mode_d = MODE_IDLE;
          if (char_i == 8'h0a) begin
            line_d = line_inc;
            col_d  = '0;
          end else if (char_i == " " || char_i == 8'h09 || char_i == 8'h0d) begin
            col_d = col_inc;
          end else if (pk != KIND_NONE) begin
            b_vld      = 1'b1;
            b_tok.kind = pk;
            b_tok.line = line_q;
            b_tok.scol = col_inc;
            b_tok.ecol = col_inc;
          end else begin
            tstart_d = col_inc;
            err_d    = 1'b0;
            if (is_op(char_i)) begin
              pend_d = char_i;
              mode_d = MODE_OP;
            end else if (char_i inside {["0":"9"]}) begin
              acc_d   = ValW'(char_i - 8'h30);
              radix_d = 2'd0;
              mode_d  = (char_i == "0") ? MODE_ZERO : MODE_DEC;
            end else if (is_word(char_i)) begin
              win_d  = {{(WinW-8){1'b0}}, char_i};
              wlen_d = LenW'(1);
              mode_d = MODE_IDENT;
            end
          end
        end
      end
    end
    if (cfg_we_i) line_d = cfg_wdata_i;
  end

  always_comb begin
    tok0_o = a_vld ? a_tok : b_tok;
    tok1_o = b_tok;
    tok0_o.last = !(a_vld && b_vld);
    tok1_o.last = 1'b1;
    tok_cnt_o = 2'(a_vld) + 2'(b_vld);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pend_q   <= '0;
      acc_q    <= '0;
      radix_q  <= '0;
      win_q    <= '0;
      wlen_q   <= '0;
      line_q   <= 16'd1;
      col_q    <= '0;
      tstart_q <= '0;
      err_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      radix_q  <= radix_d;
      win_q    <= win_d;
      wlen_q   <= wlen_d;
      line_q   <= line_d;
      col_q    <= col_d;
      tstart_q <= tstart_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tst_out_fifo.sv =====
// Four-entry result queue taking up to two tokens and giving one per cycle while the consumer is ready.
`default_nettype none

module tst_out_fifo import tst_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  tok_t            push0_i,
  input  tok_t            push1_i,
  output logic            room_o,
  output logic            valid_o,
  input  wire logic       pop_i,
  output tok_t            data_o
);

  tok_t       mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 3'd0;
  assign room_o  = cnt_q <= 3'd2;
  assign pop     = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_q + 2'd1] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_cnt_i;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_cnt_i) - 3'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result queue count out of range");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> room_o)
    else $error("push into full result queue");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 3'd0 || cnt_q == 3'd4 || 2'(cnt_q) == wr_q - rd_q)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hdl/source_token_scanner.sv =====
// Top level: input request register, scanner core and result queue.
// A byte request passes through the input request register and the result queue before reaching m_axis.
// Throughput: one byte per cycle while the result queue has room, the scanner making a single pass per byte.
// A byte that yields two tokens gives them out one after the other, the first with tlast low.
// Reset: asynchronous, active low; idle scan state, line counter 1, columns 0.
`default_nettype none

module source_token_scanner import tst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // char_byte
  input  wire logic        s_axis_tuser,   // end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // number_value, line_number, start_column,
                                           // end_column, zero pad
  output logic [6:0]       m_axis_tuser,   // token_kind, malformed
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_eoi_q;
  logic       room, fire;
  tok_t       tok0, tok1, out_tok;
  logic [1:0] tok_cnt;

  assign fire          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser;
    end
  end

  tst_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (fire),
    .char_i     (in_char_q),
    .eoi_i      (in_eoi_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .tok0_o     (tok0),
    .tok1_o     (tok1),
    .tok_cnt_o  (tok_cnt)
  );

  tst_out_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(fire ? tok_cnt : 2'd0),
    .push0_i   (tok0),
    .push1_i   (tok1),
    .room_o    (room),
    .valid_o   (m_axis_tvalid),
    .pop_i     (m_axis_tready),
    .data_o    (out_tok)
  );

  assign m_axis_tdata = {1'b0, out_tok.ecol, out_tok.scol, out_tok.line, out_tok.value};
  assign m_axis_tuser = {out_tok.bad, out_tok.kind};
  assign m_axis_tlast = out_tok.last;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the source token scanner: byte stream in, checked tokens out.
`default_nettype none

module testbench;
  import tst_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } src_req_t;

  localparam logic [63:0] VMAX = 64'h7FFF_FFFF;
  localparam int NO_KIND = 255;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [6:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  source_token_scanner i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  src_req_t src_q[$];
  tok_t     tok_q[$];
  int       fails = 0;
  int       tokens_checked = 0;
  int       eof_seen = 0;
  int       bytes_sent = 0;
  bit       took = 1'b0;
  int       ready_pct = 100;
  int       hold_ask = 0;

  // scanner shadow state
  mode_e       mode = MODE_IDLE;
  logic [7:0]  pend = '0;
  logic [63:0] acc = '0;
  logic [1:0]  rad = '0;
  logic [7:0]  win[8];
  int          wlen = 0;
  int          lnum = 1;
  int          cnum = 0;
  int          tsc = 0;
  bit          err = 1'b0;

  string kw_txt[19] = '{"let", "func", "return", "package", "static", "if", "else",
                        "while", "do", "switch", "for", "foreach", "break", "breakall",
                        "continue", "loop", "in", "true", "false"};
  int    kw_code[19] = '{35, 36, 37, 38, 39, 40, 41, 42, 43, 44, 45, 46, 47, 48, 49,
                         50, 51, 52, 52};

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int single_op(logic [7:0] p);
    case (p)
      "+": return 11;
      "-": return 12;
      "*": return 13;
      "/": return 14;
      "%": return 15;
      "!": return 16;
      ">": return 17;
      "<": return 18;
      "=": return 19;
      "&": return 20;
      default: return 21;
    endcase
  endfunction

  function automatic int assign_op(logic [7:0] p);
    case (p)
      "+": return 24;
      "-": return 25;
      "*": return 26;
      "/": return 27;
      "%": return 28;
      "!": return 29;
      ">": return 30;
      "<": return 31;
      "=": return 32;
      default: return NO_KIND;
    endcase
  endfunction

  function automatic int punct_code(logic [7:0] c);
    case (c)
      "(": return 0;
      ")": return 1;
      "[": return 2;
      "]": return 3;
      "{": return 4;
      "}": return 5;
      ":": return 6;
      ";": return 7;
      ".": return 8;
      ",": return 9;
      "^": return 10;
      default: return -1;
    endcase
  endfunction

  function automatic int digit_val(logic [7:0] c, int base);
    int v;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 10;
    else return -1;
    return v < base ? v : -1;
  endfunction

  function automatic bit word_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "_";
  endfunction

  function automatic int base_of(logic [1:0] r);
    case (r)
      2'd1: return 2;
      2'd2: return 8;
      2'd3: return 16;
      default: return 10;
    endcase
  endfunction

  function automatic int word_kind();
    int i;
    bit same;
    if (wlen > 8) return 34;
    for (int k = 0; k < 19; k++) begin
      if (kw_txt[k].len() == wlen) begin
        same = 1'b1;
        for (i = 0; i < wlen; i++) if (kw_txt[k][i] != win[i]) same = 1'b0;
        if (same) return kw_code[k];
      end
    end
    return 34;
  endfunction

  task automatic emit(int kind, logic [63:0] val, int sc, int ec, bit bad);
    tok_t t;
    t.kind  = 6'(kind);
    t.value = val[30:0];
    t.line  = 16'(lnum);
    t.scol  = 16'(sc);
    t.ecol  = 16'(ec);
    t.bad   = bad;
    t.last  = 1'b0;
    tok_q.push_back(t);
  endtask

  task automatic next_line();
    if (lnum < 65535) lnum++;
    cnum = 0;
  endtask

  task automatic add_digit(int d, int base);
    if (acc > (VMAX - d) / base) begin
      acc = VMAX;
      err = 1'b1;
    end else begin
      acc = acc * base + d;
    end
  endtask

  task automatic close_token(int endc);
    case (mode)
      MODE_OP: emit(single_op(pend), 0, tsc, tsc, 0);
      MODE_SEP, MODE_PFX: begin
        err = 1'b1;
        emit(KIND_NUMBER, acc, tsc, endc, err);
      end
      MODE_ZERO, MODE_DEC, MODE_PDIG: emit(KIND_NUMBER, acc, tsc, endc, err);
      MODE_IDENT: emit(word_kind(), 0, tsc, endc, 0);
      default: ;
    endcase
    mode = MODE_IDLE;
  endtask

  task automatic extend_token(logic [7:0] c, int col, int prev, output bit kept);
    int d;
    kept = 1'b1;
    case (mode)
      MODE_IDLE: begin
        kept = 1'b0;
        return;
      end
      MODE_OP: begin
        if (pend == "/" && c == "/") begin mode = MODE_LCOM; return; end
        if (pend == "/" && c == "*") begin mode = MODE_BCOM; return; end
        if (c == "=" && assign_op(pend) != NO_KIND) begin
          emit(assign_op(pend), 0, tsc, col, 0);
          mode = MODE_IDLE;
          return;
        end
        if (c == pend && (c == "&" || c == "|")) begin
          emit(c == "&" ? KIND_AND_AND : KIND_OR_OR, 0, tsc, col, 0);
          mode = MODE_IDLE;
          return;
        end
      end
      MODE_LCOM: begin
        if (c == "\n") begin
          next_line();
          mode = MODE_IDLE;
        end
        return;
      end
      MODE_BCOM, MODE_BSTAR: begin
        if (mode == MODE_BSTAR && c == "/") mode = MODE_IDLE;
        else if (c == "*") mode = MODE_BSTAR;
        else begin
          mode = MODE_BCOM;
          if (c == "\n") next_line();
        end
        return;
      end
      MODE_ZERO, MODE_DEC: begin
        if (mode == MODE_ZERO && (c == "b" || c == "o" || c == "d" || c == "x")) begin
          rad = c == "b" ? 2'd1 : c == "o" ? 2'd2 : c == "x" ? 2'd3 : 2'd0;
          mode = MODE_PFX;
          return;
        end
        d = digit_val(c, 10);
        if (d >= 0) begin add_digit(d, 10); mode = MODE_DEC; return; end
        if (c == "_") begin mode = MODE_SEP; return; end
      end
      MODE_SEP: begin
        d = digit_val(c, 10);
        if (d >= 0) begin add_digit(d, 10); mode = MODE_DEC; return; end
      end
      MODE_PFX, MODE_PDIG: begin
        d = digit_val(c, base_of(rad));
        if (d >= 0) begin add_digit(d, base_of(rad)); mode = MODE_PDIG; return; end
      end
      MODE_IDENT: begin
        if (word_ch(c)) begin
          if (wlen < 8) win[wlen] = c;
          if (wlen <= 8) wlen++;
          return;
        end
      end
      default: ;
    endcase
    close_token(prev);
    kept = 1'b0;
  endtask

  task automatic start_token(logic [7:0] c, int col);
    if (c == "\n") begin next_line(); return; end
    if (c == " " || c == "\t" || c == "\r") return;
    if (punct_code(c) >= 0) begin emit(punct_code(c), 0, col, col, 0); return; end
    tsc = col;
    err = 1'b0;
    if (assign_op(c) != NO_KIND || c == "&" || c == "|") begin
      pend = c;
      mode = MODE_OP;
    end else if (c >= "0" && c <= "9") begin
      acc = c - "0";
      rad = 2'd0;
      mode = c == "0" ? MODE_ZERO : MODE_DEC;
    end else if (word_ch(c)) begin
      foreach (win[i]) win[i] = '0;
      win[0] = c;
      wlen = 1;
      mode = MODE_IDENT;
    end
  endtask

  task automatic predict_tokens(src_req_t r);
    int n0;
    int prev;
    int col;
    bit kept;
    n0 = tok_q.size();
    if (r.eoi) begin
      close_token(cnum);
      if (lnum < 65535) lnum++;
      emit(KIND_EOF, 0, 0, 0, 0);
    end else begin
      prev = cnum;
      col = prev < 65535 ? prev + 1 : 65535;
      cnum = col;
      extend_token(r.ch, col, prev, kept);
      if (!kept) start_token(r.ch, col);
    end
    if (tok_q.size() > n0) tok_q[tok_q.size() - 1].last = 1'b1;
  endtask

  // request driver
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk) begin
    src_req_t r;
    if (rst_n && !(s_axis_tvalid && !took)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (src_q.size() > 0) begin
        r = src_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.ch;
        s_axis_tuser  <= r.eoi;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // token receiver
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) < ready_pct;
    end
  end

  // sample requests, predict and check tokens
  always @(posedge clk) begin
    tok_t want;
    took = s_axis_tvalid && s_axis_tready && rst_n;
    if (cfg_we) begin
      lnum = cfg_wdata;
    end
    if (took) begin
      predict_tokens('{ch: s_axis_tdata, eoi: s_axis_tuser});
    end
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (tok_q.size() == 0) begin
        $error("token with no prediction: kind %0d", m_axis_tuser[5:0]);
        fails++;
      end else begin
        want = tok_q.pop_front();
        tokens_checked++;
        if (want.kind == KIND_EOF) eof_seen++;
        if (m_axis_tuser[5:0] != want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, m_axis_tuser[5:0]);
          fails++;
        end
        if (m_axis_tdata[30:0] != want.value) begin
          $error("number_value: expected %0d, got %0d", want.value, m_axis_tdata[30:0]);
          fails++;
        end
        if (m_axis_tdata[46:31] != want.line) begin
          $error("line_number: expected %0d, got %0d", want.line, m_axis_tdata[46:31]);
          fails++;
        end
        if (m_axis_tdata[62:47] != want.scol) begin
          $error("start_column: expected %0d, got %0d", want.scol, m_axis_tdata[62:47]);
          fails++;
        end
        if (m_axis_tdata[78:63] != want.ecol) begin
          $error("end_column: expected %0d, got %0d", want.ecol, m_axis_tdata[78:63]);
          fails++;
        end
        if (m_axis_tuser[6] != want.bad) begin
          $error("malformed: expected %0d, got %0d", want.bad, m_axis_tuser[6]);
          fails++;
        end
        if (m_axis_tlast != want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
          fails++;
        end
      end
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      src_q.push_back('{ch: s[i], eoi: 1'b0});
      bytes_sent++;
    end
  endtask

  task automatic push_byte(logic [7:0] c);
    src_q.push_back('{ch: c, eoi: 1'b0});
    bytes_sent++;
  endtask

  task automatic push_eoi();
    src_q.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
    bytes_sent++;
  endtask

  task automatic push_digits(int base, int n);
    string hex;
    hex = "0123456789abcdef";
    for (int i = 0; i < n; i++) push_byte(hex[$urandom_range(0, base - 1)]);
  endtask

  task automatic push_snippet();
    string ops;
    string wc;
    string pfx;
    int pick;
    int base;
    ops = "+-*/%!><=&|";
    wc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    pfx = "bodx";
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2: begin
        push_text(kw_txt[$urandom_range(0, 18)]);
        if ($urandom_range(0, 3) == 0) push_byte(wc[$urandom_range(0, 62)]);
      end
      3, 4: begin
        push_byte(wc[$urandom_range(0, 52)]);
        if (wc[0] == "a") push_byte("a");
        repeat ($urandom_range(0, 11)) push_byte(wc[$urandom_range(0, 62)]);
      end
      5, 6: begin
        push_byte(8'("1") + 8'($urandom_range(0, 8)));
        repeat ($urandom_range(0, 11)) begin
          if ($urandom_range(0, 5) == 0) push_byte("_");
          push_digits(10, 1);
        end
        if ($urandom_range(0, 6) == 0) push_byte("_");
      end
      7, 8: begin
        push_byte("0");
        pick = $urandom_range(0, 3);
        push_byte(pfx[pick]);
        base = pick == 0 ? 2 : pick == 1 ? 8 : pick == 2 ? 10 : 16;
        push_digits(base, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 34));
      end
      9, 10, 11: begin
        push_byte(ops[$urandom_range(0, 10)]);
        pick = $urandom_range(0, 3);
        if (pick == 0) push_byte("=");
        else if (pick == 1) push_byte(ops[$urandom_range(0, 10)]);
      end
      12: begin
        push_text("//");
        repeat ($urandom_range(0, 8)) push_byte(wc[$urandom_range(0, 62)]);
        push_byte("\n");
      end
      13: begin
        push_text("/*");
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 3))
            0: push_byte("*");
            1: push_byte("\n");
            default: push_byte(wc[$urandom_range(0, 62)]);
          endcase
        end
        push_text($urandom_range(0, 1) ? "*/" : "**/");
      end
      14: push_byte(punct_code(8'("(")) == 0 ? 8'("(") + 8'($urandom_range(0, 1)) : 8'("("));
      15: push_text("[]{}:;.,^");
      16: push_byte($urandom_range(0, 1) ? 8'("\n") : 8'("\t"));
      17: push_byte("\r");
      default: push_byte(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 2) == 0) push_byte(" ");
    if ($urandom_range(0, 39) == 0) push_eoi();
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (src_q.size() != 0 || s_axis_tvalid || tok_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start_line(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int goal;
    goal = bytes_sent + n;
    while (bytes_sent < goal) push_snippet();
    push_eoi();
  endtask

  initial begin
    foreach (win[i]) win[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_text("/*a**/&=|=||0b 1_x 0x7fffffff 99999999999 breakall continues");
    push_byte(8'hff);
    push_text("\n0d+=");
    push_eoi();
    push_text("/* open");
    push_eoi();
    wait_drained();

    ready_pct = 70;
    random_phase(120);
    wait_drained();

    write_start_line(16'd0);
    ready_pct = 100;
    hold_ask++;
    random_phase(120);
    wait_drained();

    write_start_line(16'hFFFF);
    ready_pct = 30;
    random_phase(120);
    wait_drained();

    write_start_line(16'($urandom_range(2, 65534)));
    ready_pct = 85;
    repeat (20) push_byte(" ");
    push_text("x 1");
    random_phase(100);
    wait_drained();

    $display("Run covered %0d requests over four start-line settings, %0d tokens checked",
             bytes_sent, tokens_checked);
    $display("including %0d end-of-file tokens, with long and random output stalls", eof_seen);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
